>>> sv/pmd_pkg.sv
`timescale 1ns / 1ps

package pmd_pkg;

  localparam int WINDOW_BYTES = 16;
  localparam int LEN_W = 4;
  localparam logic [LEN_W-1:0] MIN_LENGTH = 4'd12;
  localparam logic [LEN_W-1:0] GATE_LENGTH = 4'd7;

  localparam logic [31:0] TAG_JUMB = "jumb";
  localparam logic [31:0] TAG_JUMD = "jumd";
  localparam logic [31:0] TAG_C2PA = "c2pa";
  localparam logic [31:0] TAG_CABX = "caBX";
  localparam logic [31:0] TAG_FTYP = "ftyp";
  localparam logic [23:0] TAG_CR = "cr:";
  localparam logic [55:0] TAG_XPACKET = "xpacket";
  localparam logic [103:0] TAG_XAP = {8'h61, 8'h64, 8'h6f, 8'h62, 8'h65, 8'h2e, 8'h63,
                                       8'h6f, 8'h6d, 8'h2f, 8'h78, 8'h61, 8'h70};
  localparam logic [87:0] TAG_CAUTH = "contentauth";
  localparam logic [127:0] TAG_UUID = 128'hd8fec3d6_1b0e483c_92975828_877ec481;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic has_manifest;
    logic box_form_found;
    logic uuid_form_found;
    logic xmp_form_found;
  } out_item_t;

  typedef struct packed {
    logic box;
    logic uuid;
    logic cr;
    logic marker;
    logic ftyp;
  } match_t;

endpackage

>>> sv/pmd_match.sv
`timescale 1ns / 1ps

module pmd_match #(
  parameter int WindowBytes = pmd_pkg::WINDOW_BYTES
) (
  input  logic [WindowBytes*8-1:0] window,
  output pmd_pkg::match_t          hits
);
  import pmd_pkg::*;

  // newest byte sits in the low bits of the window
  always_comb begin
    hits.box    = (window[31:0] == TAG_JUMB) || (window[31:0] == TAG_JUMD) ||
                  (window[31:0] == TAG_C2PA) || (window[31:0] == TAG_CABX);
    hits.uuid   = (window[127:0] == TAG_UUID);
    hits.cr     = (window[23:0] == TAG_CR);
    hits.marker = (window[55:0] == TAG_XPACKET) || (window[103:0] == TAG_XAP) ||
                  (window[87:0] == TAG_CAUTH);
    hits.ftyp   = (window[31:0] == TAG_FTYP);
  end

endmodule

>>> sv/pmd_scan.sv
`timescale 1ns / 1ps

module pmd_scan #(
  parameter int WindowBytes = pmd_pkg::WINDOW_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  pmd_pkg::in_item_t   item,
  output pmd_pkg::out_item_t  result
);
  import pmd_pkg::*;

  localparam int HistW = (WindowBytes - 1) * 8;

  logic [HistW-1:0]         hist_r, hist_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic                     gate_r, gate_nxt;
  logic                     box_r, box_nxt;
  logic                     uuid_r, uuid_nxt;
  logic                     cr_r, cr_nxt;
  logic                     marker_r, marker_nxt;
  logic [WindowBytes*8-1:0] window;
  match_t                   hits;
  logic                     gate_now, box_now, uuid_now, cr_now, marker_now;
  logic                     long_enough, box_f, uuid_f, xmp_f;
  logic [LEN_W-1:0]         len_step;

  assign window = {hist_r, item.data_byte};

  pmd_match #(.WindowBytes(WindowBytes)) u_match (
    .window (window),
    .hits   (hits)
  );

  always_comb begin
    gate_now    = gate_r || ((len_r == GATE_LENGTH) && hits.ftyp);
    box_now     = box_r || hits.box;
    uuid_now    = uuid_r || hits.uuid;
    cr_now      = cr_r || hits.cr;
    marker_now  = marker_r || hits.marker;
    len_step    = (len_r >= MIN_LENGTH) ? MIN_LENGTH : len_r + 1'b1;
    long_enough = (len_step >= MIN_LENGTH);
    box_f       = long_enough && box_now;
    uuid_f      = long_enough && uuid_now && gate_now;
    xmp_f       = long_enough && cr_now && marker_now;

    result.has_manifest    = box_f || uuid_f || xmp_f;
    result.box_form_found  = box_f;
    result.uuid_form_found = uuid_f;
    result.xmp_form_found  = xmp_f;

    hist_nxt   = hist_r;
    len_nxt    = len_r;
    gate_nxt   = gate_r;
    box_nxt    = box_r;
    uuid_nxt   = uuid_r;
    cr_nxt     = cr_r;
    marker_nxt = marker_r;
    if (step) begin
      if (item.last_byte) begin
        hist_nxt   = '0;
        len_nxt    = '0;
        gate_nxt   = 1'b0;
        box_nxt    = 1'b0;
        uuid_nxt   = 1'b0;
        cr_nxt     = 1'b0;
        marker_nxt = 1'b0;
      end else begin
        hist_nxt   = window[HistW-1:0];
        len_nxt    = len_step;
        gate_nxt   = gate_now;
        box_nxt    = box_now;
        uuid_nxt   = uuid_now;
        cr_nxt     = cr_now;
        marker_nxt = marker_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r   <= '0;
      len_r    <= '0;
      gate_r   <= 1'b0;
      box_r    <= 1'b0;
      uuid_r   <= 1'b0;
      cr_r     <= 1'b0;
      marker_r <= 1'b0;
    end else begin
      hist_r   <= hist_nxt;
      len_r    <= len_nxt;
      gate_r   <= gate_nxt;
      box_r    <= box_nxt;
      uuid_r   <= uuid_nxt;
      cr_r     <= cr_nxt;
      marker_r <= marker_nxt;
    end
  end

endmodule

>>> sv/provenance_manifest_detector.sv
`timescale 1ns / 1ps

// Scans a file one byte per transfer and, on the byte marked last, delivers one
// result transfer with the box, uuid and xmp form flags and the overall verdict
// (all zero for files under 12 bytes); other bytes give no result. A byte is
// taken every cycle: it lands in an input register, the window comparators and
// sticky flags work on it there, and when the last byte steps the verdict goes
// into an output register that raises out_valid. Only a last byte waiting on a
// full, stalled output register holds the input back.
// After each last byte all scan state returns to its reset value for the next file.
module provenance_manifest_detector #(
  parameter int WindowBytes = pmd_pkg::WINDOW_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pmd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pmd_pkg::out_item_t out_data
);
  import pmd_pkg::*;

  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t result;
  logic      step;
  logic      out_free;

  assign out_free = !out_valid_r || out_ready;
  assign step     = in_valid_r && (!in_item_r.last_byte || out_free);
  assign in_ready = !in_valid_r || step;

  pmd_scan #(.WindowBytes(WindowBytes)) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .result (result)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ready) begin
      in_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = step && in_item_r.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
    if (step && in_item_r.last_byte) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pmd_pkg::*;

  typedef enum int {
    SIG_JUMB, SIG_JUMD, SIG_C2PA, SIG_CABX, SIG_FTYP,
    SIG_CR, SIG_XPACKET, SIG_XAP, SIG_CAUTH, SIG_UUID
  } sig_e;
  localparam int SIG_COUNT = 10;

  typedef enum int {FORM_NOISE, FORM_BOX, FORM_UUID, FORM_XMP} form_e;

  localparam int RANDOM_ITEMS = 450;
  localparam int RANDOM_FILES = 20;
  localparam int LONG_HOLD = 400;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic [7:0] file_bytes[$];
  int         in_burst = 0;
  int         out_burst = 0;
  int         random_items = 0;
  int         random_files = 0;

  function automatic logic [127:0] sig_bits(sig_e s);
    case (s)
      SIG_JUMB:    return "jumb";
      SIG_JUMD:    return "jumd";
      SIG_C2PA:    return "c2pa";
      SIG_CABX:    return "caBX";
      SIG_FTYP:    return "ftyp";
      SIG_CR:      return "cr:";
      SIG_XPACKET: return "xpacket";
      SIG_XAP:     return 128'h61646f62652e636f6d2f786170;
      SIG_CAUTH:   return "contentauth";
      default:     return 128'hd8fec3d6_1b0e483c_92975828_877ec481;
    endcase
  endfunction

  function automatic int sig_len(sig_e s);
    case (s)
      SIG_CR:      return 3;
      SIG_XPACKET: return 7;
      SIG_XAP:     return 13;
      SIG_CAUTH:   return 11;
      SIG_UUID:    return 16;
      default:     return 4;
    endcase
  endfunction

  class manifest_scoreboard;
    logic [7:0] history [15];
    int unsigned seen_len;
    bit ftyp_gate, box_hit, uuid_hit, cr_hit, marker_hit;
    out_item_t verdict_q[$];
    int unsigned error_count;
    int unsigned verdict_count;

    function new();
      error_count = 0;
      verdict_count = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      foreach (history[i]) history[i] = 8'h00;
      seen_len = 0;
      ftyp_gate = 0;
      box_hit = 0;
      uuid_hit = 0;
      cr_hit = 0;
      marker_hit = 0;
    endfunction

    function bit tail_is(logic [7:0] win [16], sig_e s);
      logic [127:0] v;
      int n;
      v = sig_bits(s);
      n = sig_len(s);
      for (int i = 0; i < n; i++) begin
        if (win[16 - n + i] != v[8 * (n - 1 - i) +: 8]) return 0;
      end
      return 1;
    endfunction

    function void note_byte(in_item_t it);
      logic [7:0] win [16];
      bit long_enough;
      out_item_t v;
      for (int i = 0; i < 15; i++) win[i] = history[i];
      win[15] = it.data_byte;
      if (seen_len == 7 && tail_is(win, SIG_FTYP)) ftyp_gate = 1;
      if (tail_is(win, SIG_JUMB) || tail_is(win, SIG_JUMD) ||
          tail_is(win, SIG_C2PA) || tail_is(win, SIG_CABX)) box_hit = 1;
      if (tail_is(win, SIG_UUID)) uuid_hit = 1;
      if (tail_is(win, SIG_CR)) cr_hit = 1;
      if (tail_is(win, SIG_XPACKET) || tail_is(win, SIG_XAP) || tail_is(win, SIG_CAUTH))
        marker_hit = 1;
      seen_len = (seen_len >= 12) ? 12 : seen_len + 1;
      for (int i = 0; i < 15; i++) history[i] = win[i + 1];
      if (it.last_byte) begin
        long_enough = (seen_len >= 12);
        v.box_form_found = long_enough && box_hit;
        v.uuid_form_found = long_enough && uuid_hit && ftyp_gate;
        v.xmp_form_found = long_enough && cr_hit && marker_hit;
        v.has_manifest = v.box_form_found || v.uuid_form_found || v.xmp_form_found;
        verdict_q = {verdict_q, v};
        clear_scan();
      end
    endfunction

    function void check_verdict(out_item_t got);
      string names [4];
      out_item_t want;
      names = '{"xmp_form_found", "uuid_form_found", "box_form_found", "has_manifest"};
      verdict_count++;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual %b", $time, got);
        error_count++;
        return;
      end
      want = verdict_q.pop_front();
      for (int b = 0; b < 4; b++) begin
        if (got[b] !== want[b]) begin
          $display("%0t: %s mismatch, expected %b, actual %b", $time, names[b], want[b],
                   got[b]);
          error_count++;
        end
      end
    endfunction
  endclass

  manifest_scoreboard sb = new();

  provenance_manifest_detector uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_byte(in_data);
    if (rst_n && out_valid && out_ready) sb.check_verdict(out_data);
  end

  function automatic int draw_gap(ref int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) burst = $urandom_range(8, 40);
    return $urandom_range(0, 11);
  endfunction

  task automatic send_byte(in_item_t it);
    int gap;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_file();
    in_item_t it;
    for (int i = 0; i < file_bytes.size(); i++) begin
      it.data_byte = file_bytes[i];
      it.last_byte = (i == file_bytes.size() - 1);
      send_byte(it);
    end
  endtask

  task automatic plant(sig_e s, int at, bit spoil);
    logic [127:0] v;
    int n;
    int k;
    v = sig_bits(s);
    n = sig_len(s);
    for (int i = 0; i < n; i++) file_bytes[at + i] = v[8 * (n - 1 - i) +: 8];
    if (spoil) begin
      k = at + $urandom_range(0, n - 1);
      file_bytes[k] = file_bytes[k] ^ 8'($urandom_range(1, 255));
    end
  endtask

  task automatic plant_somewhere(sig_e s, bit spoil);
    if (sig_len(s) <= file_bytes.size())
      plant(s, $urandom_range(0, file_bytes.size() - sig_len(s)), spoil);
  endtask

  task automatic make_file();
    int n;
    int shape;
    sig_e s;
    logic [127:0] v;
    form_e form;
    shape = $urandom_range(0, 9);
    n = (shape < 3) ? $urandom_range(1, 11) :
        (shape < 8) ? $urandom_range(12, 24) : $urandom_range(25, 48);
    form = form_e'($urandom_range(0, 3));
    file_bytes.delete();
    repeat (n) begin
      if ($urandom_range(0, 1)) begin
        file_bytes = {file_bytes, 8'($urandom_range(0, 255))};
      end else begin
        // characters of the signatures make near misses more likely
        s = sig_e'($urandom_range(0, SIG_COUNT - 1));
        v = sig_bits(s);
        file_bytes = {file_bytes, v[8 * $urandom_range(0, sig_len(s) - 1) +: 8]};
      end
    end
    if (n >= 8 && ($urandom_range(0, 1) || form == FORM_UUID)) begin
      if ($urandom_range(0, 5) == 0) plant(SIG_FTYP, $urandom_range(0, n - 4), 0);
      else plant(SIG_FTYP, 4, $urandom_range(0, 7) == 0);
    end
    case (form)
      FORM_BOX: plant_somewhere(sig_e'($urandom_range(SIG_JUMB, SIG_CABX)), 0);
      FORM_UUID: begin
        if (n >= 24) plant(SIG_UUID, $urandom_range(8, n - 16), 0);
        else plant_somewhere(SIG_UUID, 0);
      end
      FORM_XMP: begin
        plant_somewhere(SIG_CR, 0);
        plant_somewhere(sig_e'($urandom_range(SIG_XPACKET, SIG_CAUTH)), 0);
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 2))
      plant_somewhere(sig_e'($urandom_range(0, SIG_COUNT - 1)), $urandom_range(0, 1));
  endtask

  initial begin
    int stall;
    bit held_off;
    held_off = 0;
    wait (rst_n);
    forever begin
      stall = draw_gap(out_burst);
      // one long hold-off so that the output backs up and the input stalls
      if (!held_off && sb.verdict_count >= 6) begin
        held_off = 1;
        stall = 0;
        out_ready <= 1'b0;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single byte file at the top of the byte range
    file_bytes = '{8'hff};
    send_file();
    // tag inside a file shorter than 12 bytes, ending in a partial tag
    file_bytes = '{"j", "u", "m", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "j", "u"};
    send_file();
    // tag must not complete across files; ftyp gate and cr: without a marker
    file_bytes = '{"m", "b", 8'h00, "A", "f", "t", "y", "p", "c", "r", ":", 8'hff};
    send_file();

    while (random_items < RANDOM_ITEMS || random_files < RANDOM_FILES) begin
      make_file();
      send_file();
      random_items += file_bytes.size();
      random_files++;
    end
    in_valid <= 1'b0;

    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
